@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define AST_IMPLY(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define AST_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/fpd_pkg.sv @@
// ----------------------------------------------------------------------------
// fpd_pkg
// types and constants shared by the decimal display formatter
// ----------------------------------------------------------------------------
package fpd_pkg;

    // format descriptor of one row request
    typedef struct packed {
        logic       pad_zero;
        logic [3:0] width;
        logic [2:0] frac;
    } t_fmt;

    // converter and emitter sequencer
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_PREP,
        ST_EMIT
    } t_back_state;

    localparam int          FMT_BITS   = 8;
    localparam int          OUT_W      = 16;
    localparam int          QDEPTH     = 2;
    localparam logic [3:0]  SYM_BLANK  = 4'd10;
    localparam logic [3:0]  SYM_ZERO   = 4'd0;
    localparam logic [3:0]  BCD_ADJ_TH = 4'd5;
    localparam logic [3:0]  BCD_ADJ    = 4'd3;

endpackage

@@ src/fpd_front.sv @@
// ----------------------------------------------------------------------------
// fpd_front
// accepts request words, clamps the row width and hands them to the queue
// ----------------------------------------------------------------------------
module fpd_front #(
    parameter int MAX_WIDTH  = 8,
    parameter int VALUE_BITS = 32,
    parameter int IN_W       = 40
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [IN_W-1:0]       i_s_tdata,
    output logic                  o_push,
    input  logic                  i_push_ready,
    output logic [VALUE_BITS-1:0] o_value,
    output fpd_pkg::t_fmt         o_fmt
);

    localparam logic [3:0] WMAX = (MAX_WIDTH > 15) ? 4'd15 : 4'(MAX_WIDTH);

    logic                  r_valid;
    logic [VALUE_BITS-1:0] r_value;
    fpd_pkg::t_fmt         r_fmt;
    fpd_pkg::t_fmt         w_fmt;
    logic [3:0]            w_width_raw;

    // unpack and classify the incoming word
    always_comb begin
        w_width_raw     = i_s_tdata[VALUE_BITS+6:VALUE_BITS+3];
        w_fmt.frac      = i_s_tdata[VALUE_BITS+2:VALUE_BITS];
        w_fmt.pad_zero  = i_s_tdata[VALUE_BITS+7];
        if (w_width_raw == 4'd0) begin
            w_fmt.width = 4'd1;
        end else if (w_width_raw > WMAX) begin
            w_fmt.width = WMAX;
        end else begin
            w_fmt.width = w_width_raw;
        end
    end

    assign o_s_tready = !r_valid || i_push_ready;
    assign o_push     = r_valid;
    assign o_value    = r_value;
    assign o_fmt      = r_fmt;

    // holding stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_valid <= i_s_tvalid;
        end
    end

    // holding stage payload
    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_value <= i_s_tdata[VALUE_BITS-1:0];
            r_fmt   <= w_fmt;
        end
    end

endmodule

@@ src/fpd_queue.sv @@
// ----------------------------------------------------------------------------
// fpd_queue
// two-entry request queue between front and back
// ----------------------------------------------------------------------------
module fpd_queue #(
    parameter int VALUE_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    output logic                  o_push_ready,
    input  logic [VALUE_BITS-1:0] i_value,
    input  fpd_pkg::t_fmt         i_fmt,
    output logic                  o_valid,
    input  logic                  i_pop,
    output logic [VALUE_BITS-1:0] o_value,
    output fpd_pkg::t_fmt         o_fmt
);

    logic [VALUE_BITS-1:0] r_mem_value [fpd_pkg::QDEPTH];
    fpd_pkg::t_fmt         r_mem_fmt   [fpd_pkg::QDEPTH];
    logic                  r_wr;
    logic                  r_rd;
    logic [1:0]            r_cnt;
    logic                  w_wr_en;
    logic                  w_rd_en;

    assign o_push_ready = (r_cnt != 2'(fpd_pkg::QDEPTH));
    assign o_valid      = (r_cnt != 2'd0);
    assign w_wr_en      = i_push && o_push_ready;
    assign w_rd_en      = i_pop && o_valid;
    assign o_value      = r_mem_value[r_rd];
    assign o_fmt        = r_mem_fmt[r_rd];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr_en) begin
                r_wr <= ~r_wr;
            end
            if (w_rd_en) begin
                r_rd <= ~r_rd;
            end
            if (w_wr_en && !w_rd_en) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (!w_wr_en && w_rd_en) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem_value[r_wr] <= i_value;
            r_mem_fmt[r_wr]   <= i_fmt;
        end
    end

endmodule

@@ src/fpd_back.sv @@
// ----------------------------------------------------------------------------
// fpd_back
// shift-add-3 binary to bcd conversion and per-column symbol emission
// ----------------------------------------------------------------------------
module fpd_back #(
    parameter int VALUE_BITS = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_q_valid,
    output logic                       o_q_pop,
    input  logic [VALUE_BITS-1:0]      i_q_value,
    input  fpd_pkg::t_fmt              i_q_fmt,
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    output logic [fpd_pkg::OUT_W-1:0]  o_m_tdata,
    output logic                       o_m_tlast
);

    localparam int NDIG  = (VALUE_BITS * 77) / 256 + 1;
    localparam int NDIGB = (NDIG > 8) ? NDIG : 8;
    localparam int DW    = $clog2(NDIGB + 1);
    localparam int IW    = $clog2(NDIGB);
    localparam int CW    = $clog2(VALUE_BITS);

    fpd_pkg::t_back_state        r_state, n_state;
    logic [VALUE_BITS-1:0]       r_bin, n_bin;
    logic [NDIGB-1:0][3:0]       r_bcd, n_bcd;
    logic [NDIGB-1:0][3:0]       w_adj;
    logic [4*NDIGB-1:0]          w_adj_flat;
    logic [DW-1:0]               r_nd, n_nd;
    logic [CW-1:0]               r_cnt, n_cnt;
    fpd_pkg::t_fmt               r_fmt, n_fmt;
    logic [DW-1:0]               r_ndig, n_ndig;
    logic [DW-1:0]               r_pad, n_pad;
    logic                        r_ovf, n_ovf;
    logic [3:0]                  r_col, n_col;
    logic                        r_tvalid, n_tvalid;
    logic [fpd_pkg::OUT_W-1:0]   r_tdata, n_tdata;
    logic                        r_tlast, n_tlast;

    logic [DW-1:0]               w_min_dig;
    logic [DW-1:0]               w_width;
    logic [DW-1:0]               w_ndig;
    logic [DW-1:0]               w_col;
    logic [DW-1:0]               w_d;
    logic [DW-1:0]               w_idx;
    logic [DW-1:0]               w_dot_pos;
    logic                        w_is_pad;
    logic [3:0]                  w_sym;
    logic                        w_dot;
    logic                        w_slot_free;

    // add-3 adjust on every bcd digit
    always_comb begin
        for (int i = 0; i < NDIGB; i++) begin
            w_adj[i] = (r_bcd[i] >= fpd_pkg::BCD_ADJ_TH) ? r_bcd[i] + fpd_pkg::BCD_ADJ
                                                         : r_bcd[i];
        end
    end

    assign w_adj_flat = w_adj;

    // row geometry and the symbol of the current column
    always_comb begin
        w_min_dig = DW'(r_fmt.frac) + DW'(1);
        w_width   = DW'(r_fmt.width);
        w_ndig    = (r_nd > w_min_dig) ? r_nd : w_min_dig;
        w_col     = DW'(r_col);
        w_is_pad  = (w_col < r_pad);
        w_d       = w_col - r_pad;
        w_idx     = r_ndig - DW'(1) - w_d;
        w_dot_pos = r_ndig - DW'(r_fmt.frac) - DW'(1);
        if (w_is_pad) begin
            w_sym = r_fmt.pad_zero ? fpd_pkg::SYM_ZERO : fpd_pkg::SYM_BLANK;
        end else begin
            w_sym = r_bcd[w_idx[IW-1:0]];
        end
        w_dot       = (r_fmt.frac != 3'd0) && !w_is_pad && (w_d == w_dot_pos);
        w_slot_free = !r_tvalid || i_m_tready;
    end

    assign o_q_pop    = (r_state == fpd_pkg::ST_IDLE) && i_q_valid;
    assign o_m_tvalid = r_tvalid;
    assign o_m_tdata  = r_tdata;
    assign o_m_tlast  = r_tlast;

    // sequencer: next state and datapath loads
    always_comb begin
        n_state  = r_state;
        n_bin    = r_bin;
        n_bcd    = r_bcd;
        n_nd     = r_nd;
        n_cnt    = r_cnt;
        n_fmt    = r_fmt;
        n_ndig   = r_ndig;
        n_pad    = r_pad;
        n_ovf    = r_ovf;
        n_col    = r_col;
        n_tvalid = r_tvalid && !i_m_tready;
        n_tdata  = r_tdata;
        n_tlast  = r_tlast;
        case (r_state)
            fpd_pkg::ST_IDLE: begin
                if (i_q_valid) begin
                    n_bin   = i_q_value;
                    n_bcd   = '0;
                    n_nd    = '0;
                    n_cnt   = CW'(VALUE_BITS - 1);
                    n_fmt   = i_q_fmt;
                    n_state = fpd_pkg::ST_CONV;
                end
            end
            fpd_pkg::ST_CONV: begin
                n_bcd = {w_adj_flat[4*NDIGB-2:0], r_bin[VALUE_BITS-1]};
                n_bin = {r_bin[VALUE_BITS-2:0], 1'b0};
                // the significant digit count grows by at most one per shift
                if ((r_nd < DW'(NDIGB)) && (n_bcd[r_nd[IW-1:0]] != 4'd0)) begin
                    n_nd = r_nd + DW'(1);
                end
                n_cnt = r_cnt - CW'(1);
                if (r_cnt == '0) begin
                    n_state = fpd_pkg::ST_PREP;
                end
            end
            fpd_pkg::ST_PREP: begin
                n_ndig  = w_ndig;
                n_ovf   = (w_ndig > w_width);
                n_pad   = (w_ndig > w_width) ? '0 : w_width - w_ndig;
                n_col   = 4'd0;
                n_state = fpd_pkg::ST_EMIT;
            end
            fpd_pkg::ST_EMIT: begin
                if (w_slot_free) begin
                    n_tvalid = 1'b1;
                    n_tdata  = {7'd0, r_ovf, w_dot, w_sym, r_col[2:0]};
                    n_tlast  = (r_col == r_fmt.width - 4'd1);
                    n_col    = r_col + 4'd1;
                    if (r_col == r_fmt.width - 4'd1) begin
                        n_state = fpd_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = fpd_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= fpd_pkg::ST_IDLE;
            r_tvalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_tvalid <= n_tvalid;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_bin   <= n_bin;
        r_bcd   <= n_bcd;
        r_nd    <= n_nd;
        r_cnt   <= n_cnt;
        r_fmt   <= n_fmt;
        r_ndig  <= n_ndig;
        r_pad   <= n_pad;
        r_ovf   <= n_ovf;
        r_col   <= n_col;
        r_tdata <= n_tdata;
        r_tlast <= n_tlast;
    end

endmodule

@@ src/fixed_point_decimal_display_formatter.sv @@
// Path: an accepted word goes through the front holding register and the queue to the back end,
// which converts it with the one-bit-per-cycle shift-add-3 converter (ST_CONV), sizes the row
// (ST_PREP) and then emits one position per cycle while the output is not stalled (ST_EMIT).
// A two-entry queue lets the front take the next words while a row is still being emitted.
// Reset: synchronous, active low; clears the handshake and sequencer state only.
// ----------------------------------------------------------------------------
// fixed_point_decimal_display_formatter
// formats an unsigned count as a right-aligned decimal row with an optional decimal point
// ----------------------------------------------------------------------------
module fixed_point_decimal_display_formatter #(
    parameter int MAX_WIDTH  = 8,
    parameter int VALUE_BITS = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // value, frac_digits[2:0], width[3:0], pad_zero, zero fill
    input  logic [((VALUE_BITS+15)/8)*8-1:0] i_s_axis_tdata,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // position[2:0], symbol[3:0], dot_after, overflow, zero fill
    output logic [fpd_pkg::OUT_W-1:0]        o_m_axis_tdata,
    // last position of the row
    output logic                             o_m_axis_tlast
);

    localparam int IN_W = ((VALUE_BITS + 15) / 8) * 8;

    logic                  w_push;
    logic                  w_push_ready;
    logic [VALUE_BITS-1:0] w_f_value;
    fpd_pkg::t_fmt         w_f_fmt;
    logic                  w_q_valid;
    logic                  w_q_pop;
    logic [VALUE_BITS-1:0] w_q_value;
    fpd_pkg::t_fmt         w_q_fmt;

    // request intake and width clamp
    fpd_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .VALUE_BITS (VALUE_BITS),
        .IN_W       (IN_W)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_axis_tvalid),
        .o_s_tready   (o_s_axis_tready),
        .i_s_tdata    (i_s_axis_tdata),
        .o_push       (w_push),
        .i_push_ready (w_push_ready),
        .o_value      (w_f_value),
        .o_fmt        (w_f_fmt)
    );

    // request queue
    fpd_queue #(
        .VALUE_BITS (VALUE_BITS)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .o_push_ready (w_push_ready),
        .i_value      (w_f_value),
        .i_fmt        (w_f_fmt),
        .o_valid      (w_q_valid),
        .i_pop        (w_q_pop),
        .o_value      (w_q_value),
        .o_fmt        (w_q_fmt)
    );

    // conversion and emission
    fpd_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (w_q_valid),
        .o_q_pop    (w_q_pop),
        .i_q_value  (w_q_value),
        .i_q_fmt    (w_q_fmt),
        .o_m_tvalid (o_m_axis_tvalid),
        .i_m_tready (i_m_axis_tready),
        .o_m_tdata  (o_m_axis_tdata),
        .o_m_tlast  (o_m_axis_tlast)
    );

endmodule

@@ src/fpd_checker.sv @@
// ----------------------------------------------------------------------------
// fpd_checker
// port-level checks on the row output stream
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fpd_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_tvalid,
    input logic                      i_tready,
    input logic [fpd_pkg::OUT_W-1:0] i_tdata,
    input logic                      i_tlast
);

    logic       r_mid;
    logic [2:0] r_col;
    logic       r_ovf;
    logic       w_acc;

    assign w_acc = i_tvalid && i_tready;

    // expected column and row-constant overflow flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid <= 1'b0;
            r_col <= 3'd0;
        end else if (w_acc) begin
            r_mid <= !i_tlast;
            r_col <= i_tlast ? 3'd0 : r_col + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_ovf <= i_tdata[8];
        end
    end

    // a stalled word holds
    `AST_NEXT(a_stall_hold, i_clk, i_rst_n, i_tvalid && !i_tready, i_tvalid && $stable(i_tdata) && $stable(i_tlast), "output word changed while stalled")

    // columns count up from zero in every row
    `AST_IMPLY(a_col_order, i_clk, i_rst_n, w_acc, i_tdata[2:0] == r_col, "column out of order")

    // overflow is the same on every word of a row
    `AST_IMPLY(a_ovf_const, i_clk, i_rst_n, w_acc && r_mid, i_tdata[8] == r_ovf, "overflow changed within a row")

    // symbol code is a digit or a blank, and a blank never carries the point
    `AST_IMPLY(a_sym_range, i_clk, i_rst_n, w_acc, (i_tdata[6:3] < fpd_pkg::SYM_BLANK) || ((i_tdata[6:3] == fpd_pkg::SYM_BLANK) && !i_tdata[7]), "bad symbol or point on blank")

endmodule

bind fixed_point_decimal_display_formatter fpd_checker u_fpd_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_tvalid (o_m_axis_tvalid),
    .i_tready (i_m_axis_tready),
    .i_tdata  (o_m_axis_tdata),
    .i_tlast  (o_m_axis_tlast)
);
